[sv/texture_sampler_bilinear_wrap_defines.svh]
// ----------------------------------------------------------------------------
// texture sampler assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef TEXTURE_SAMPLER_BILINEAR_WRAP_DEFINES_SVH
`define TEXTURE_SAMPLER_BILINEAR_WRAP_DEFINES_SVH

// implication checked on every edge outside reset
`define TSB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: label failed");

// next-cycle implication outside reset
`define TSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: label failed");

`endif

[sv/tsbw_pkg.sv]
// ----------------------------------------------------------------------------
// texture sampler package
// types, constants and helpers shared by the sampler files
// ----------------------------------------------------------------------------
package tsbw_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    REG_WRAP_U      = 3'd0,
    REG_WRAP_V      = 3'd1,
    REG_FILTER_MODE = 3'd2,
    REG_TEX_WIDTH   = 3'd3,
    REG_TEX_HEIGHT  = 3'd4
  } reg_idx_t;

  localparam int unsigned IN_W  = 1 + 8 + 8 + 32 + 32 + 32;
  localparam int unsigned IN_TW = ((IN_W + 7) / 8) * 8;

  // blend one byte lane: (a*(256-w)+b*w+128)>>8
  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] w);
    logic [17:0] s;
    s = 18'(a) * (18'd256 - 18'(w)) + 18'(b) * 18'(w) + 18'd128;
    return s[15:8];
  endfunction

  function automatic logic [31:0] lerp32(input logic [31:0] a, input logic [31:0] b,
                                         input logic [7:0] w);
    logic [31:0] r;
    for (int k = 0; k < 4; k++) r[8*k +: 8] = lerp8(a[8*k +: 8], b[8*k +: 8], w);
    return r;
  endfunction

endpackage

[sv/texture_sampler_bilinear_wrap.sv]
// ----------------------------------------------------------------------------
// texture_sampler_bilinear_wrap
// rgba8 texture store with nearest and bilinear sampling, repeat or clamp
// ----------------------------------------------------------------------------
// a sample item is wrapped and scaled, read from the store, blended along u, then along v into the output register
// throughput: one item per cycle; the store is kept in two copies, each read
//   at two addresses a cycle, so a bilinear footprint is one access
// stalls: the whole pipeline holds while the output item waits
// reset clears configuration and pipeline valid bits; texel memory is
//   undefined until written, no clearing pass
module texture_sampler_bilinear_wrap #(
  parameter int unsigned MAX_WIDTH  = tsbw_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = tsbw_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // op, texel_x, texel_y, texel_rgba, coord_u, coord_v (lowest first), zero pad
  input  logic [tsbw_pkg::IN_TW-1:0] s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // red, green, blue, alpha
  output logic [31:0]                m_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [8:0]                 cfg_data
);
  import tsbw_pkg::*;

  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned SWX   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SWY   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  // config registers
  logic       wrap_u, wrap_v, filter_mode;
  logic [8:0] tex_width, tex_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_u <= 1'b0; wrap_v <= 1'b0; filter_mode <= 1'b0;
      tex_width <= 9'd1; tex_height <= 9'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WRAP_U:      wrap_u      <= cfg_data[0];
        REG_WRAP_V:      wrap_v      <= cfg_data[0];
        REG_FILTER_MODE: filter_mode <= cfg_data[0];
        REG_TEX_WIDTH:   tex_width   <= cfg_data;
        REG_TEX_HEIGHT:  tex_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [SWX-1:0] w_eff;
  logic [SWY-1:0] h_eff;
  always_comb begin
    if (tex_width == 9'd0) w_eff = SWX'(1);
    else if (32'(tex_width) > MAX_WIDTH) w_eff = SWX'(MAX_WIDTH);
    else w_eff = SWX'(tex_width);
    if (tex_height == 9'd0) h_eff = SWY'(1);
    else if (32'(tex_height) > MAX_HEIGHT) h_eff = SWY'(MAX_HEIGHT);
    else h_eff = SWY'(tex_height);
  end

  // pipeline advance: stall everything when output is held
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  logic acc;
  assign acc = s_tvalid && s_tready;

  logic        in_op;
  logic [7:0]  in_x, in_y;
  logic [31:0] in_rgba, in_u, in_v;
  assign in_op   = s_tdata[0];
  assign in_x    = s_tdata[8:1];
  assign in_y    = s_tdata[16:9];
  assign in_rgba = s_tdata[48:17];
  assign in_u    = s_tdata[80:49];
  assign in_v    = s_tdata[112:81];

  // ---------------- stage 1: wrap coordinates, scale
  function automatic logic [15:0] wrapc(input logic [31:0] c, input logic cl);
    if (!cl) return c[15:0];
    if (c[31]) return 16'd0;
    if (c[30:16] != '0) return 16'hFFFF;
    return c[15:0];
  endfunction

  logic           s1_v, s1_op;
  logic [31:0]    s1_rgba;
  logic [7:0]     s1_x, s1_y;
  logic [SWX+15:0] s1_pu;
  logic [SWY+15:0] s1_pv;
  logic           s1_fm, s1_wu, s1_wv;
  logic [SWX-1:0] s1_w;
  logic [SWY-1:0] s1_h;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= acc;
    if (adv) begin
      s1_op   <= in_op;
      s1_x    <= in_x;
      s1_y    <= in_y;
      s1_rgba <= in_rgba;
      s1_pu   <= (SWX+16)'(wrapc(in_u, wrap_u)) * (SWX+16)'(w_eff);
      s1_pv   <= (SWY+16)'(wrapc(in_v, wrap_v)) * (SWY+16)'(h_eff);
      s1_fm   <= filter_mode;
      s1_wu   <= wrap_u;
      s1_wv   <= wrap_v;
      s1_w    <= w_eff;
      s1_h    <= h_eff;
    end
  end

  // ---------------- stage 2: indices, weights, memory addresses
  logic [SWX+15:0] su;
  logic [SWY+15:0] sv;
  logic [XW-1:0]   x0, x1, xn;
  logic [YW-1:0]   y0, y1, yn;
  logic [7:0]      wu, wv;
  logic            u_neg, v_neg;
  logic [SWX-1:0]  iu;
  logic [SWY-1:0]  iv;

  always_comb begin
    su    = s1_pu - (SWX+16)'(32'h8000);
    sv    = s1_pv - (SWY+16)'(32'h8000);
    u_neg = s1_pu < (SWX+16)'(32'h8000);
    v_neg = s1_pv < (SWY+16)'(32'h8000);
    iu    = su[SWX+15:16];
    iv    = sv[SWY+15:16];
    wu    = su[15:8];
    wv    = sv[15:8];
    xn    = XW'(s1_pu[SWX+15:16]);
    yn    = YW'(s1_pv[SWY+15:16]);
    // x0: iu, or column -1 wrapped to w-1 (repeat) or clamped to 0
    if (u_neg) x0 = s1_wu ? XW'(0) : XW'(s1_w - SWX'(1));
    else x0 = XW'(iu);
    if (u_neg) x1 = XW'(0);
    else if ((iu + SWX'(1)) >= s1_w) x1 = s1_wu ? XW'(s1_w - SWX'(1)) : XW'(0);
    else x1 = XW'(iu + SWX'(1));
    if (v_neg) y0 = s1_wv ? YW'(0) : YW'(s1_h - SWY'(1));
    else y0 = YW'(iv);
    if (v_neg) y1 = YW'(0);
    else if ((iv + SWY'(1)) >= s1_h) y1 = s1_wv ? YW'(s1_h - SWY'(1)) : YW'(0);
    else y1 = YW'(iv + SWY'(1));
    if (!s1_fm) begin
      x0 = xn; x1 = xn; y0 = yn; y1 = yn; wu = 8'd0; wv = 8'd0;
    end
  end

  // two copies of the store: one serves row y0, the other row y1,
  // each read at x0 and x1
  logic [31:0] mem_lo [DEPTH];
  logic [31:0] mem_hi [DEPTH];

  logic [AW-1:0] ra00, ra10, ra01, ra11;
  always_comb begin
    ra00 = AW'(32'(y0) * MAX_WIDTH + 32'(x0));
    ra10 = AW'(32'(y0) * MAX_WIDTH + 32'(x1));
    ra01 = AW'(32'(y1) * MAX_WIDTH + 32'(x0));
    ra11 = AW'(32'(y1) * MAX_WIDTH + 32'(x1));
  end

  // write path at stage 2; a write and a sample never share stage 2, so a
  // sample always reads after every earlier write has landed
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  always_comb begin
    wr_en   = s1_v && (s1_op == OP_WRITE) && (32'(s1_x) < MAX_WIDTH)
              && (32'(s1_y) < MAX_HEIGHT) && adv;
    wr_addr = AW'(32'(s1_y) * MAX_WIDTH + 32'(s1_x));
  end

  logic [31:0] t00, t10, t01, t11;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_lo[wr_addr] <= s1_rgba;
      mem_hi[wr_addr] <= s1_rgba;
    end
    if (adv) begin
      t00 <= mem_lo[ra00];
      t10 <= mem_lo[ra10];
      t01 <= mem_hi[ra01];
      t11 <= mem_hi[ra11];
    end
  end

  logic       s2_v;
  logic [7:0] s2_wu, s2_wv;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v && (s1_op == OP_SAMPLE);
    if (adv) begin
      s2_wu <= wu;
      s2_wv <= wv;
    end
  end

  // ---------------- stage 3: blend along u
  logic        s3_v;
  logic [31:0] s3_lo, s3_hi;
  logic [7:0]  s3_wv;
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
    if (adv) begin
      s3_lo <= lerp32(t00, t10, s2_wu);
      s3_hi <= lerp32(t01, t11, s2_wu);
      s3_wv <= s2_wv;
    end
  end

  // ---------------- stage 4: blend along v into output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= s3_v;
    if (adv) m_tdata <= lerp32(s3_lo, s3_hi, s3_wv);
  end

endmodule

[sv/tsbw_checker.sv]
// ----------------------------------------------------------------------------
// tsbw_checker
// port-level checks on the sampler's streams
// ----------------------------------------------------------------------------
`include "texture_sampler_bilinear_wrap_defines.svh"

module tsbw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        cfg_ready
);
  `TSB_ASSERT_NEXT(out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `TSB_ASSERT_IMP(ready_free, clk, rst, !m_tvalid, s_tready)
  `TSB_ASSERT_IMP(cfg_always, clk, rst, 1'b1, cfg_ready)
  `TSB_ASSERT_IMP(stall_block, clk, rst, m_tvalid && !m_tready, !s_tready)
endmodule

bind texture_sampler_bilinear_wrap tsbw_checker u_tsbw_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .cfg_ready(cfg_ready)
);

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// texture sampler testbench
// fills each texture region before sampling it, then mixes texel writes and
// nearest or bilinear samples under random flow control; every sample result
// is checked against an in-bench model of the store and filter
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import tsbw_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_TW-1:0]     s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [2:0]           cfg_index = '0;
  logic [8:0]           cfg_data = '0;

  logic [IN_TW-1:0]     pending_items[$];
  logic [31:0]          expected_pixels[$];
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   errors = 0;
  int                   quiet_cycles = 0;

  // model state
  logic [31:0]          texels[0:65535];
  bit                   written[0:65535];
  logic                 wrap_u_m, wrap_v_m, filter_m;
  logic [8:0]           width_m, height_m;

  texture_sampler_bilinear_wrap dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned eff_size(input logic [8:0] r);
    if (r == 0) return 1;
    return (r > 256) ? 256 : int'(r);
  endfunction

  function automatic logic [15:0] wrap_frac(input logic signed [31:0] c, input logic clampm);
    if (!clampm) return c[15:0];
    if (c < 0) return 16'h0000;
    if (c > 32'sh0000_FFFF) return 16'hFFFF;
    return c[15:0];
  endfunction

  function automatic int unsigned wrap_texel(input longint i, input int unsigned size,
                                             input logic clampm);
    if (clampm) begin
      if (i < 0) return 0;
      if (i >= size) return size - 1;
      return int'(i);
    end
    return int'((i + size) % size);
  endfunction

  function automatic logic [31:0] mix_pixels(input logic [31:0] a, input logic [31:0] b,
                                             input logic [7:0] w);
    logic [31:0] r;
    int unsigned c;
    for (int k = 0; k < 4; k++) begin
      c = (a[8*k +: 8] * (256 - w) + b[8*k +: 8] * w + 128) >> 8;
      r[8*k +: 8] = c[7:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] texel_at(input int unsigned x, input int unsigned y);
    return texels[16'(y * 256 + x)];
  endfunction

  function automatic logic [31:0] sample_pixel(input logic [31:0] u, input logic [31:0] v);
    int unsigned w, h, x0, x1, y0, y1;
    logic [15:0] tu, tv;
    longint su, sv, iu, iv;
    logic [63:0] su_b, sv_b;
    logic [31:0] lower, upper;
    w = eff_size(width_m);
    h = eff_size(height_m);
    tu = wrap_frac(u, wrap_u_m);
    tv = wrap_frac(v, wrap_v_m);
    if (!filter_m) return texel_at((tu * w) >> 16, (tv * h) >> 16);
    su = longint'(tu) * w - 32768;
    sv = longint'(tv) * h - 32768;
    iu = ((su + 65536) >>> 16) - 1;
    iv = ((sv + 65536) >>> 16) - 1;
    su_b = su;
    sv_b = sv;
    x0 = wrap_texel(iu, w, wrap_u_m);
    x1 = wrap_texel(iu + 1, w, wrap_u_m);
    y0 = wrap_texel(iv, h, wrap_v_m);
    y1 = wrap_texel(iv + 1, h, wrap_v_m);
    lower = mix_pixels(texel_at(x0, y0), texel_at(x1, y0), su_b[15:8]);
    upper = mix_pixels(texel_at(x0, y1), texel_at(x1, y1), su_b[15:8]);
    return mix_pixels(lower, upper, sv_b[15:8]);
  endfunction

  function automatic logic [IN_TW-1:0] pack_item(input logic op, input logic [7:0] x,
                                                 input logic [7:0] y, input logic [31:0] rgba,
                                                 input logic [31:0] u, input logic [31:0] v);
    return {{(IN_TW - IN_W){1'b0}}, v, u, rgba, y, x, op};
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata  <= pending_items.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // model update on accepted items and register writes
  always @(posedge clk) begin
    if (rst) begin
      wrap_u_m <= 1'b0; wrap_v_m <= 1'b0; filter_m <= 1'b0;
      width_m <= 9'd1; height_m <= 9'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_WRAP_U:      wrap_u_m <= cfg_data[0];
          REG_WRAP_V:      wrap_v_m <= cfg_data[0];
          REG_FILTER_MODE: filter_m <= cfg_data[0];
          REG_TEX_WIDTH:   width_m  <= cfg_data;
          REG_TEX_HEIGHT:  height_m <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tdata[0] == OP_WRITE) texels[{s_tdata[16:9], s_tdata[8:1]}] = s_tdata[48:17];
        else expected_pixels.push_back(sample_pixel(s_tdata[80:49], s_tdata[112:81]));
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        report("unexpected result", m_tdata, 32'h0);
      end else begin
        want = expected_pixels.pop_front();
        if (m_tdata[7:0] != want[7:0])
          report("red", 32'(m_tdata[7:0]), 32'(want[7:0]));
        if (m_tdata[15:8] != want[15:8])
          report("green", 32'(m_tdata[15:8]), 32'(want[15:8]));
        if (m_tdata[23:16] != want[23:16])
          report("blue", 32'(m_tdata[23:16]), 32'(want[23:16]));
        if (m_tdata[31:24] != want[31:24])
          report("alpha", 32'(m_tdata[31:24]), 32'(want[31:24]));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [8:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_items.size() != 0 || s_tvalid ||
                              expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(1)) return $urandom();
    return 32'($signed($urandom_range(262143)) - 131072);
  endfunction

  // write every texel of the active region that has not been written yet,
  // then random texel writes and samples
  task automatic run_phase(input int unsigned w, input int unsigned h, input int n);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        if (!written[16'(y * 256 + x)]) begin
          written[16'(y * 256 + x)] = 1'b1;
          pending_items.push_back(pack_item(OP_WRITE, 8'(x), 8'(y), $urandom(), 32'd0, 32'd0));
        end
    for (int i = 0; i < n; i++) begin
      int unsigned x, y;
      if ($urandom_range(3) == 0) begin
        x = $urandom_range(255);
        y = $urandom_range(255);
        written[16'(y * 256 + x)] = 1'b1;
        pending_items.push_back(pack_item(OP_WRITE, 8'(x), 8'(y), $urandom(), $urandom(),
                                          $urandom()));
      end else begin
        pending_items.push_back(pack_item(OP_SAMPLE, 8'($urandom()), 8'($urandom()),
                                          $urandom(), rand_coord(), rand_coord()));
      end
    end
  endtask

  task automatic configure(input logic wu, input logic wv, input logic f,
                           input logic [8:0] w, input logic [8:0] h);
    write_reg(REG_WRAP_U, {8'($urandom()), wu});
    write_reg(REG_WRAP_V, {8'($urandom()), wv});
    write_reg(REG_FILTER_MODE, {8'($urandom()), f});
    write_reg(REG_TEX_WIDTH, w);
    write_reg(REG_TEX_HEIGHT, h);
    run_phase(eff_size(w), eff_size(h), 25);
    wait_drained();
  endtask

  initial begin
    send_idle_pct = 11;
    recv_idle_pct = 83;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset configuration, single texel, coordinate extremes
    written[0] = 1'b1;
    written[65535] = 1'b1;
    pending_items.push_back(pack_item(OP_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF, 32'd0, 32'd0));
    pending_items.push_back(pack_item(OP_WRITE, 8'd255, 8'd255, 32'h0000_0000, 32'd0, 32'd0));
    pending_items.push_back(pack_item(OP_SAMPLE, 8'd0, 8'd0, 32'd0, 32'h8000_0000,
                                      32'h7FFF_FFFF));
    pending_items.push_back(pack_item(OP_SAMPLE, 8'd0, 8'd0, 32'd0, 32'h7FFF_FFFF,
                                      32'h8000_0000));
    pending_items.push_back(pack_item(OP_SAMPLE, 8'd0, 8'd0, 32'd0, 32'h0000_0000,
                                      32'hFFFF_FFFF));
    pending_items.push_back(pack_item(OP_SAMPLE, 8'd0, 8'd0, 32'd0, 32'h0000_FFFF,
                                      32'h0001_0000));
    pending_items.push_back(pack_item(OP_WRITE, 8'd0, 8'd0, 32'h1234_5678, 32'd0, 32'd0));
    pending_items.push_back(pack_item(OP_SAMPLE, 8'd0, 8'd0, 32'd0, 32'h0000_8000,
                                      32'hFFFF_8000));
    wait_drained();

    configure(1'b0, 1'b0, 1'b1, 9'd4, 9'd4);
    configure(1'b1, 1'b1, 1'b1, 9'd3, 9'd5);
    send_idle_pct = 83;
    recv_idle_pct = 11;
    configure(1'b1, 1'b0, 1'b0, 9'd12, 9'd1);
    // zero width acts as one
    configure(1'b0, 1'b1, 1'b1, 9'd0, 9'd6);
    configure(1'b1, 1'b1, 1'b0, 9'd7, 9'd2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(1'b0, 1'b0, 1'b1, 9'd2, 9'd3);
    configure(1'b1, 1'b0, 1'b1, 9'd8, 9'd5);
    // oversize width acts as the maximum
    configure(1'b0, 1'b1, 1'b0, 9'd511, 9'd1);

    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/tsbw_pkg.sv
sv/texture_sampler_bilinear_wrap.sv
sv/tsbw_checker.sv
verif/tb_top.sv
